### hdl/spt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_pkg
// Shared types and constants of the square-of-prime test block.
// ----------------------------------------------------------------------------
package spt_pkg;

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_ROOT   = 9'b000000010,
      ST_SQEND  = 9'b000000100,
      ST_LIMIT  = 9'b000001000,
      ST_LIMEND = 9'b000010000,
      ST_DIV    = 9'b000100000,
      ST_DVEND  = 9'b001000000,
      ST_CHECK  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   localparam int FIRST_CAND    = 5;
   localparam int CAND_STEP     = 6;
   localparam int CAND_PAIR_GAP = 2;
   localparam int DIV_TWO       = 2;
   localparam int DIV_THREE     = 3;
   localparam int LAST_NONPRIME = 1;
   localparam int LAST_SMALL    = 3;

endpackage

### hdl/spt_sub_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spt_sub_unit
// Shared subtract/compare unit: difference of two operands and a >= flag.
// Serves the square root steps, the division steps and the loop bound test.
// ----------------------------------------------------------------------------
module spt_sub_unit #(
   parameter int WIDTH = 18
) (
   input  logic [WIDTH-1:0] op_a,
   input  logic [WIDTH-1:0] op_b,
   output logic [WIDTH-1:0] diff,
   output logic             ge
);

   logic [WIDTH:0] wide;

   assign wide = {1'b0, op_a} - {1'b0, op_b};
   assign diff = wide[WIDTH-1:0];
   assign ge   = ~wide[WIDTH];

endmodule

### hdl/square_of_prime_test_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_of_prime_test_top
// Reports whether an unsigned value is the square of a prime.
//
// Request channel (req_valid/req_ready/req_value) takes one transaction at a
// time; req_ready is high only while the block is idle. Response channel
// (rsp_valid/rsp_ready/rsp_is_t_prime) returns one transaction per request.
// The value's floor root is found one bit per cycle, then the root of the root
// for the loop bound. Each trial divisor runs on a one-bit-per-cycle restoring
// divider, and every pair of divisors adds one bound check. All steps share
// one subtract/compare unit, which sets the rate. A new request is taken as
// soon as the result is in the output register; if the receiver stalls, the
// next result waits in the DONE state until the output register frees.
// Reset returns to idle and drops any pending result.
// ----------------------------------------------------------------------------
module square_of_prime_test_top #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_is_t_prime
);

   localparam int RW = (VALUE_WIDTH + 1) / 2;
   localparam int SW = 2 * RW;
   localparam int UW = RW + 2;
   localparam int CW = $clog2(RW);

   spt_pkg::state_type state_ff, state_in;

   logic [SW-1:0] src_ff, src_in;
   logic [UW-1:0] rem_ff, rem_in;
   logic [RW-1:0] acc_ff, acc_in;
   logic [RW-1:0] root_ff, root_in;
   logic [RW-1:0] lim_ff, lim_in;
   logic [RW-1:0] cand_ff, cand_in;
   logic [RW-1:0] div_ff, div_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          second_ff, second_in;
   logic          first_ff, first_in;
   logic          ans_ff, ans_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_data_ff, rsp_data_in;

   logic [UW-1:0] op_a;
   logic [UW-1:0] op_b;
   logic [UW-1:0] diff;
   logic          ge;

   spt_sub_unit #(.WIDTH(UW)) u_sub (
      .op_a (op_a),
      .op_b (op_b),
      .diff (diff),
      .ge   (ge)
   );

   assign req_ready      = (state_ff == spt_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_is_t_prime = rsp_data_ff;

   // operand select for the shared unit
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         spt_pkg::ST_ROOT, spt_pkg::ST_LIMIT: begin
            op_a = {rem_ff[UW-3:0], src_ff[SW-1:SW-2]};
            op_b = {acc_ff, 2'b01};
         end
         spt_pkg::ST_DIV: begin
            op_a = {1'b0, rem_ff[RW-1:0], src_ff[SW-1]};
            op_b = {2'b00, div_ff};
         end
         spt_pkg::ST_CHECK: begin
            op_a = {2'b00, lim_ff};
            op_b = {2'b00, cand_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      src_in       = src_ff;
      rem_in       = rem_ff;
      acc_in       = acc_ff;
      root_in      = root_ff;
      lim_in       = lim_ff;
      cand_in      = cand_ff;
      div_in       = div_ff;
      cnt_in       = cnt_ff;
      second_in    = second_ff;
      first_in     = first_ff;
      ans_in       = ans_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         spt_pkg::ST_IDLE: begin
            if (req_valid) begin
               src_in   = SW'(req_value);
               rem_in   = '0;
               acc_in   = '0;
               cnt_in   = CW'(RW - 1);
               state_in = spt_pkg::ST_ROOT;
            end
         end
         spt_pkg::ST_ROOT, spt_pkg::ST_LIMIT: begin
            rem_in = ge ? diff : op_a;
            acc_in = {acc_ff[RW-2:0], ge};
            src_in = {src_ff[SW-3:0], 2'b00};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = (state_ff == spt_pkg::ST_ROOT) ? spt_pkg::ST_SQEND
                                                         : spt_pkg::ST_LIMEND;
            end
         end
         spt_pkg::ST_SQEND: begin
            root_in = acc_ff;
            if (rem_ff != '0) begin
               ans_in   = 1'b0;
               state_in = spt_pkg::ST_DONE;
            end else if (acc_ff <= RW'(spt_pkg::LAST_NONPRIME)) begin
               ans_in   = 1'b0;
               state_in = spt_pkg::ST_DONE;
            end else if (acc_ff <= RW'(spt_pkg::LAST_SMALL)) begin
               ans_in   = 1'b1;
               state_in = spt_pkg::ST_DONE;
            end else begin
               src_in   = {{RW{1'b0}}, acc_ff};
               rem_in   = '0;
               acc_in   = '0;
               cnt_in   = CW'(RW - 1);
               state_in = spt_pkg::ST_LIMIT;
            end
         end
         spt_pkg::ST_LIMEND: begin
            lim_in    = acc_ff;
            div_in    = RW'(spt_pkg::DIV_TWO);
            cand_in   = RW'(spt_pkg::FIRST_CAND);
            first_in  = 1'b1;
            second_in = 1'b0;
            src_in    = {root_ff, {RW{1'b0}}};
            rem_in    = '0;
            cnt_in    = CW'(RW - 1);
            state_in  = spt_pkg::ST_DIV;
         end
         spt_pkg::ST_DIV: begin
            rem_in = ge ? diff : op_a;
            src_in = {src_ff[SW-2:0], 1'b0};
            cnt_in = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               state_in = spt_pkg::ST_DVEND;
            end
         end
         spt_pkg::ST_DVEND: begin
            if (rem_ff == '0) begin
               ans_in   = 1'b0;
               state_in = spt_pkg::ST_DONE;
            end else if (!second_ff) begin
               second_in = 1'b1;
               div_in    = first_ff ? RW'(spt_pkg::DIV_THREE)
                                    : cand_ff + RW'(spt_pkg::CAND_PAIR_GAP);
               src_in    = {root_ff, {RW{1'b0}}};
               rem_in    = '0;
               cnt_in    = CW'(RW - 1);
               state_in  = spt_pkg::ST_DIV;
            end else begin
               second_in = 1'b0;
               first_in  = 1'b0;
               if (!first_ff) begin
                  cand_in = cand_ff + RW'(spt_pkg::CAND_STEP);
               end
               state_in = spt_pkg::ST_CHECK;
            end
         end
         spt_pkg::ST_CHECK: begin
            if (ge) begin
               div_in   = cand_ff;
               src_in   = {root_ff, {RW{1'b0}}};
               rem_in   = '0;
               cnt_in   = CW'(RW - 1);
               state_in = spt_pkg::ST_DIV;
            end else begin
               ans_in   = 1'b1;
               state_in = spt_pkg::ST_DONE;
            end
         end
         spt_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ans_ff;
               state_in     = spt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = spt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spt_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         second_ff    <= 1'b0;
         first_ff     <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         second_ff    <= second_in;
         first_ff     <= first_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      acc_ff      <= acc_in;
      root_ff     <= root_in;
      lim_ff      <= lim_in;
      cand_ff     <= cand_in;
      div_ff      <= div_in;
      ans_ff      <= ans_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the square-of-prime test block.
//
// The bench drives values over the request channel and predicts each verdict
// with its own integer-root and trial-division check. A small scoreboard
// class queues the predictions and compares every response transaction in
// order. A directed set covers zero, one, small primes, composite squares,
// neighbors of squares and the width extremes. Random phases follow, with
// sender gaps and receiver stalls, one long receiver hold-off and a
// mid-phase drain.
// ----------------------------------------------------------------------------
module testbench;

   localparam int VALUE_WIDTH      = 32;
   localparam int ROOT_BITS        = (VALUE_WIDTH + 1) / 2;
   localparam int CLK_PERIOD       = 10;
   localparam int RESET_CYCLES     = 9;
   localparam int LIMIT_CYCLES     = 3_000_000;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int SETTLE_CYCLES    = 40;

   class prime_square_scoreboard;
      bit                     verdict_q[$];
      logic [VALUE_WIDTH-1:0] value_q[$];
      int                     failures;

      function new();
         failures = 0;
      endfunction

      function longint unsigned floor_sqrt(longint unsigned v);
         longint unsigned root;
         longint unsigned trial;
         root = 0;
         for (int b = ROOT_BITS - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= v) root = trial;
         end
         return root;
      endfunction

      function bit root_is_prime(longint unsigned r);
         longint unsigned c;
         if (r <= spt_pkg::LAST_NONPRIME) return 1'b0;
         if (r <= spt_pkg::LAST_SMALL) return 1'b1;
         if (r % spt_pkg::DIV_TWO == 0 || r % spt_pkg::DIV_THREE == 0) return 1'b0;
         for (c = spt_pkg::FIRST_CAND; c * c <= r; c += spt_pkg::CAND_STEP) begin
            if (r % c == 0 || r % (c + spt_pkg::CAND_PAIR_GAP) == 0) return 1'b0;
         end
         return 1'b1;
      endfunction

      function bit is_prime_square(logic [VALUE_WIDTH-1:0] v);
         longint unsigned r;
         r = floor_sqrt(longint'(v));
         return (r * r == longint'(v)) && root_is_prime(r);
      endfunction

      function void note_request(logic [VALUE_WIDTH-1:0] v);
         value_q.push_back(v);
         verdict_q.push_back(is_prime_square(v));
      endfunction

      function void check_response(bit actual);
         bit                     expected;
         logic [VALUE_WIDTH-1:0] v;
         if (verdict_q.size() == 0) begin
            $error("is_t_prime: unexpected transaction, actual %0b", actual);
            failures++;
            return;
         end
         expected = verdict_q.pop_front();
         v = value_q.pop_front();
         if (actual !== expected) begin
            $error("is_t_prime (value %0d): expected %0b, actual %0b", v, expected, actual);
            failures++;
         end
      endfunction

      function int outstanding();
         return verdict_q.size();
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_is_t_prime;

   prime_square_scoreboard sb = new();

   int gap_pct   = 0;
   int stall_pct = 0;
   int hold_left = 0;

   int sender_pct[4]   = '{0, 78, 0, 14};
   int receiver_pct[4] = '{0, 0, 78, 14};

   logic [VALUE_WIDTH-1:0] directed_values[25] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd8, 32'd9, 32'd15, 32'd16, 32'd24,
      32'd25, 32'd26, 32'd49, 32'd121, 32'd169, 32'd289, 32'd361, 32'd1225,
      32'd2401, 32'd4293001441, 32'd4294836225, 32'h5555_5555, 32'hAAAA_AAAA,
      32'h8000_0000, 32'hFFFF_FFFF
   };

   square_of_prime_test_top #(
      .VALUE_WIDTH(VALUE_WIDTH)
   ) DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_is_t_prime(rsp_is_t_prime)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mostly small roots keep trial division short; a few go to full width.
   function automatic longint unsigned random_root();
      if ($urandom_range(99) < 80) return $urandom_range(255);
      return $urandom_range((1 << ROOT_BITS) - 1);
   endfunction

   function automatic logic [VALUE_WIDTH-1:0] make_value();
      int unsigned     pick;
      longint unsigned r;
      pick = $urandom_range(99);
      r = random_root();
      if (pick < 25) begin
         if (r < spt_pkg::DIV_TWO) r = spt_pkg::DIV_TWO;
         while (!sb.root_is_prime(r)) r--;
         return VALUE_WIDTH'(r * r);
      end
      if (pick < 40) return VALUE_WIDTH'(r * r);
      if (pick < 55) return $urandom_range(1) ? VALUE_WIDTH'(r * r + 1) : VALUE_WIDTH'(r * r - 1);
      return VALUE_WIDTH'({$urandom(), $urandom()});
   endfunction

   task automatic send_value(logic [VALUE_WIDTH-1:0] v);
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_request(v);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // Response side: check accepted transactions, then pick next ready.
   initial begin
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_is_t_prime);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      rsp_ready = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_values[i]) send_value(directed_values[i]);
      drain_results();

      for (int p = 0; p < 4; p++) begin
         gap_pct   = sender_pct[p];
         stall_pct = receiver_pct[p];
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            if (p == 0 && i == 10) hold_left = HOLD_OFF_CYCLES;
            if (p == 1 && i == RANDOM_PER_PHASE / 2) drain_results();
            send_value(make_value());
         end
         drain_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #(LIMIT_CYCLES * CLK_PERIOD);
      $display("Test completed with failures");
      $finish;
   end

endmodule

### square_of_prime_test_top.f
hdl/spt_pkg.sv
hdl/spt_sub_unit.sv
hdl/square_of_prime_test_top.sv
dv/testbench.sv
